[hw/rtl/acn_pkg.sv]
// ----------------------------------------------------------------------------
// acn_pkg
// Types, constants and helpers shared by the address name cache modules.
// ----------------------------------------------------------------------------
package acn_pkg;

    // Sizing of the cache.
    localparam int USERS     = 64;
    localparam int BUCKETS   = 64;
    localparam int KEEP_FREE = 32;
    localparam int CAP       = USERS + KEEP_FREE;
    localparam int IDX_W     = 7;
    localparam int BKT_W     = $clog2(BUCKETS);
    localparam int CNT_W     = 7;

    // An index at or above the capacity means no entry.
    localparam logic [IDX_W-1:0] NIL     = IDX_W'(CAP);
    localparam logic [6:0]       REF_MAX = 7'd127;

    typedef enum logic [1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_REPLY   = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] ip_addr;
        logic [6:0]  entry_index;
        logic [15:0] reply_tag;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  result_entry;
        logic        status;
        logic        hit;
        logic        issue_query;
        logic [31:0] query_addr;
        logic [15:0] entry_tag;
        logic [31:0] entry_addr;
    } out_item_t;

    // One entry of the record memory.
    typedef struct packed {
        logic [31:0]      key;
        logic [15:0]      tag;
        logic [6:0]       refc;
        logic [IDX_W-1:0] chain;
        logic [IDX_W-1:0] prev;
        logic [IDX_W-1:0] nxt;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    localparam rec_t REC_RESET = '{key: '0, tag: '0, refc: '0,
                                   chain: NIL, prev: NIL, nxt: NIL};

    // Bit write masks for the record memory.
    localparam rec_t MASK_TAG   = '{key: '0, tag: '1, refc: '0, chain: '0, prev: '0, nxt: '0};
    localparam rec_t MASK_REF   = '{key: '0, tag: '0, refc: '1, chain: '0, prev: '0, nxt: '0};
    localparam rec_t MASK_CHAIN = '{key: '0, tag: '0, refc: '0, chain: '1, prev: '0, nxt: '0};
    localparam rec_t MASK_PREV  = '{key: '0, tag: '0, refc: '0, chain: '0, prev: '1, nxt: '0};
    localparam rec_t MASK_NEXT  = '{key: '0, tag: '0, refc: '0, chain: '0, prev: '0, nxt: '1};
    localparam rec_t MASK_LINKS = '{key: '0, tag: '0, refc: '0, chain: '0, prev: '1, nxt: '1};
    localparam rec_t MASK_RLINK = '{key: '0, tag: '0, refc: '1, chain: '0, prev: '1, nxt: '1};
    localparam rec_t MASK_ALL   = '{key: '1, tag: '1, refc: '1, chain: '1, prev: '1, nxt: '1};

    // Record memory access from the controller.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        rec_t             wr_data;
        rec_t             wr_mask;
    } rec_port_t;

    // Bucket head memory access from the controller.
    typedef struct packed {
        logic             rd_en;
        logic [BKT_W-1:0] rd_addr;
        logic             wr_en;
        logic [BKT_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
    } bkt_port_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACQ_BKT,
        S_ACQ_WALK,
        S_MISS,
        S_REUSE_RD,
        S_UNCH_BKT,
        S_UNCH_WALK,
        S_NEW_RQ,
        S_NEW_BKT,
        S_REL_RD,
        S_REP_Q,
        S_REP_RD,
        S_READ_RD,
        S_LINK,
        S_DONE
    } state_t;

    function automatic logic is_valid(input logic [IDX_W-1:0] e);
        return e < NIL;
    endfunction

endpackage

[hw/rtl/acn_ram.sv]
// ----------------------------------------------------------------------------
// acn_ram
// Single write port, single read port RAM with bit write mask and a
// registered read.
// ----------------------------------------------------------------------------
module acn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [WIDTH-1:0]         wr_mask
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Masked write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                if (wr_mask[i])
                begin
                    mem[wr_addr][i] <= wr_data[i];
                end
            end
        end
    end

    // Registered read; a read of the address being written returns the old data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/acn_ctrl.sv]
// ----------------------------------------------------------------------------
// acn_ctrl
// Command sequencer: walks hash chains, keeps the free list and the resolver
// queue, and issues the reads and writes of the two memories, masked ones for the record memory.
// ----------------------------------------------------------------------------
module acn_ctrl
    import acn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  in_item_t          req,
    output logic              done,
    input  logic              take,
    output out_item_t         result,
    output rec_port_t         rec_req,
    input  rec_t              rec_raw,
    output bkt_port_t         bkt_req,
    input  logic [IDX_W-1:0]  bkt_raw
);

    state_t                 state_reg, state_next;
    in_item_t               item_reg, item_next;
    out_item_t              res_reg, res_next;
    logic [IDX_W-1:0]       cur_reg, cur_next;
    logic [IDX_W-1:0]       steps_reg, steps_next;
    logic [IDX_W-1:0]       victim_reg, victim_next;
    logic [IDX_W-1:0]       vchain_reg, vchain_next;
    logic [BKT_W-1:0]       ubkt_reg, ubkt_next;
    logic [IDX_W-1:0]       fh_reg, fh_next, ft_reg, ft_next;
    logic [IDX_W-1:0]       qh_reg, qh_next, qt_reg, qt_next;
    logic [IDX_W-1:0]       pend_reg, pend_next;
    logic [IDX_W-1:0]       used_reg, used_next;
    logic [CNT_W-1:0]       fc_reg, fc_next;
    logic                   busy_reg, busy_next;
    logic [2:0]             sl_en_reg, sl_en_next;
    logic [2:0][IDX_W-1:0]  sl_addr_reg, sl_addr_next;
    logic [2:0][IDX_W-1:0]  sl_val_reg, sl_val_next;
    logic [1:0]             sl_idx_reg, sl_idx_next;
    logic [BUCKETS-1:0]     bvld_reg, bvld_next;
    logic [IDX_W-1:0]       rd_addr_reg;
    logic [BKT_W-1:0]       brd_addr_reg;

    rec_t                   rec_rd;
    logic [IDX_W-1:0]       bkt_rd;
    logic [BKT_W-1:0]       ip_bkt;
    logic [IDX_W-1:0]       steps_inc;
    logic                   key_match, walk_end, ref_zero, ref_sat;
    logic                   hit_inq, hit_start, rel_inq, miss_reuse, miss_fresh;

    // Entries beyond the fill count and unwritten bucket heads read as reset.
    assign rec_rd = (rd_addr_reg < used_reg) ? rec_raw : REC_RESET;
    assign bkt_rd = bvld_reg[brd_addr_reg] ? bkt_raw : NIL;

    // Decisions shared by the next state and datapath logic.
    assign ip_bkt     = item_reg.ip_addr[BKT_W-1:0];
    assign steps_inc  = steps_reg + IDX_W'(1);
    assign key_match  = rec_rd.key == item_reg.ip_addr;
    assign walk_end   = (steps_inc == NIL) || !is_valid(rec_rd.chain);
    assign ref_zero   = rec_rd.refc == '0;
    assign ref_sat    = rec_rd.refc >= REF_MAX;
    assign hit_inq    = (!ref_zero && is_valid(rec_rd.prev)) || (qh_reg == cur_reg);
    assign hit_start  = (rec_rd.tag == '0) && (cur_reg != pend_reg) && !hit_inq;
    assign rel_inq    = is_valid(rec_rd.prev) || (qh_reg == cur_reg);
    assign miss_reuse = ((fc_reg >= CNT_W'(KEEP_FREE)) || (used_reg >= NIL))
                        && is_valid(fh_reg);
    assign miss_fresh = used_reg < NIL;

    assign req_ready = state_reg == S_IDLE;
    assign done      = state_reg == S_DONE;
    assign result    = res_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.command)
                        CMD_ACQUIRE: state_next = S_ACQ_BKT;
                        CMD_RELEASE: state_next = is_valid(req.entry_index) ? S_REL_RD : S_DONE;
                        CMD_REPLY:   state_next = busy_reg ? S_REP_Q : S_DONE;
                        CMD_READ:    state_next = is_valid(req.entry_index) ? S_READ_RD : S_DONE;
                    endcase
                end
            end
            S_ACQ_BKT:   state_next = is_valid(bkt_rd) ? S_ACQ_WALK : S_MISS;
            S_ACQ_WALK:
            begin
                if (key_match)
                begin
                    state_next = ref_sat ? S_DONE : S_LINK;
                end
                else if (walk_end)
                begin
                    state_next = S_MISS;
                end
            end
            S_MISS:
            begin
                if (miss_reuse)
                begin
                    state_next = S_REUSE_RD;
                end
                else if (miss_fresh)
                begin
                    state_next = S_NEW_BKT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_REUSE_RD:  state_next = S_UNCH_BKT;
            S_UNCH_BKT:
            begin
                if (bkt_rd != victim_reg && is_valid(bkt_rd))
                begin
                    state_next = S_UNCH_WALK;
                end
                else
                begin
                    state_next = S_NEW_RQ;
                end
            end
            S_UNCH_WALK:
            begin
                if (rec_rd.chain == victim_reg || walk_end)
                begin
                    state_next = S_NEW_RQ;
                end
            end
            S_NEW_RQ:    state_next = S_NEW_BKT;
            S_NEW_BKT:   state_next = S_LINK;
            S_REL_RD:    state_next = ref_zero ? S_DONE : S_LINK;
            S_REP_Q:     state_next = is_valid(qh_reg) ? S_REP_RD : S_DONE;
            S_REP_RD:    state_next = S_LINK;
            S_READ_RD:   state_next = S_DONE;
            S_LINK:      state_next = (sl_idx_reg == 2'd2) ? S_DONE : S_LINK;
            S_DONE:      state_next = take ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath, memory accesses and list pointers.
    always_comb
    begin
        item_next    = item_reg;
        res_next     = res_reg;
        cur_next     = cur_reg;
        steps_next   = steps_reg;
        victim_next  = victim_reg;
        vchain_next  = vchain_reg;
        ubkt_next    = ubkt_reg;
        fh_next      = fh_reg;
        ft_next      = ft_reg;
        qh_next      = qh_reg;
        qt_next      = qt_reg;
        pend_next    = pend_reg;
        used_next    = used_reg;
        fc_next      = fc_reg;
        busy_next    = busy_reg;
        sl_en_next   = sl_en_reg;
        sl_addr_next = sl_addr_reg;
        sl_val_next  = sl_val_reg;
        sl_idx_next  = sl_idx_reg;
        bvld_next    = bvld_reg;
        rec_req      = '0;
        bkt_req      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next   = req;
                    res_next    = '0;
                    sl_en_next  = '0;
                    sl_idx_next = '0;
                    cur_next    = req.entry_index;
                    unique case (req.command)
                        CMD_ACQUIRE:
                        begin
                            bkt_req.rd_en   = 1'b1;
                            bkt_req.rd_addr = req.ip_addr[BKT_W-1:0];
                        end
                        CMD_RELEASE, CMD_READ:
                        begin
                            if (is_valid(req.entry_index))
                            begin
                                res_next.result_entry = req.entry_index;
                                rec_req.rd_en         = 1'b1;
                                rec_req.rd_addr       = req.entry_index;
                            end
                        end
                        CMD_REPLY:
                        begin
                            // Store the tag of the outstanding query.
                            if (busy_reg && is_valid(pend_reg))
                            begin
                                rec_req.wr_en       = 1'b1;
                                rec_req.wr_addr     = pend_reg;
                                rec_req.wr_data.tag = req.reply_tag;
                                rec_req.wr_mask     = MASK_TAG;
                            end
                        end
                    endcase
                end
            end

            S_ACQ_BKT:
            begin
                cur_next   = bkt_rd;
                steps_next = '0;
                if (is_valid(bkt_rd))
                begin
                    rec_req.rd_en   = 1'b1;
                    rec_req.rd_addr = bkt_rd;
                end
            end

            S_ACQ_WALK:
            begin
                if (key_match)
                begin
                    res_next.hit          = 1'b1;
                    res_next.result_entry = cur_reg;
                    res_next.entry_tag    = rec_rd.tag;
                    res_next.entry_addr   = rec_rd.key;
                    if (ref_sat)
                    begin
                        res_next.status = 1'b1;
                    end
                    else
                    begin
                        rec_req.wr_en        = 1'b1;
                        rec_req.wr_addr      = cur_reg;
                        rec_req.wr_mask      = MASK_RLINK;
                        rec_req.wr_data.refc = rec_rd.refc + 7'd1;
                        rec_req.wr_data.prev = ref_zero ? NIL : rec_rd.prev;
                        rec_req.wr_data.nxt  = ref_zero ? NIL : rec_rd.nxt;
                        // Take the entry off the free list.
                        if (ref_zero)
                        begin
                            fc_next        = fc_reg - CNT_W'(1);
                            sl_en_next[0]   = is_valid(rec_rd.prev);
                            sl_addr_next[0] = rec_rd.prev;
                            sl_val_next[0]  = rec_rd.nxt;
                            sl_en_next[1]   = is_valid(rec_rd.nxt);
                            sl_addr_next[1] = rec_rd.nxt;
                            sl_val_next[1]  = rec_rd.prev;
                            if (!is_valid(rec_rd.prev))
                            begin
                                fh_next = rec_rd.nxt;
                            end
                            if (!is_valid(rec_rd.nxt))
                            begin
                                ft_next = rec_rd.prev;
                            end
                        end
                        // Unresolved entry: query now or join the queue.
                        if (hit_start)
                        begin
                            if (!busy_reg)
                            begin
                                pend_next            = cur_reg;
                                busy_next            = 1'b1;
                                res_next.issue_query = 1'b1;
                                res_next.query_addr  = rec_rd.key;
                            end
                            else
                            begin
                                rec_req.wr_data.prev = qt_reg;
                                rec_req.wr_data.nxt  = NIL;
                                sl_en_next[2]        = is_valid(qt_reg);
                                sl_addr_next[2]      = qt_reg;
                                sl_val_next[2]       = cur_reg;
                                if (!is_valid(qt_reg))
                                begin
                                    qh_next = cur_reg;
                                end
                                qt_next = cur_reg;
                            end
                        end
                    end
                end
                else if (!walk_end)
                begin
                    rec_req.rd_en   = 1'b1;
                    rec_req.rd_addr = rec_rd.chain;
                    cur_next        = rec_rd.chain;
                    steps_next      = steps_inc;
                end
            end

            S_MISS:
            begin
                if (miss_reuse)
                begin
                    victim_next     = fh_reg;
                    rec_req.rd_en   = 1'b1;
                    rec_req.rd_addr = fh_reg;
                end
                else if (miss_fresh)
                begin
                    victim_next     = used_reg;
                    used_next       = used_reg + IDX_W'(1);
                    bkt_req.rd_en   = 1'b1;
                    bkt_req.rd_addr = ip_bkt;
                end
                else
                begin
                    res_next.status = 1'b1;
                end
            end

            S_REUSE_RD:
            begin
                // Unlink the oldest free entry and find its old chain.
                fc_next         = fc_reg - CNT_W'(1);
                sl_en_next[0]   = is_valid(rec_rd.prev);
                sl_addr_next[0] = rec_rd.prev;
                sl_val_next[0]  = rec_rd.nxt;
                sl_en_next[1]   = is_valid(rec_rd.nxt);
                sl_addr_next[1] = rec_rd.nxt;
                sl_val_next[1]  = rec_rd.prev;
                if (!is_valid(rec_rd.prev))
                begin
                    fh_next = rec_rd.nxt;
                end
                if (!is_valid(rec_rd.nxt))
                begin
                    ft_next = rec_rd.prev;
                end
                if (pend_reg == victim_reg)
                begin
                    pend_next = NIL;
                end
                vchain_next     = rec_rd.chain;
                ubkt_next       = rec_rd.key[BKT_W-1:0];
                bkt_req.rd_en   = 1'b1;
                bkt_req.rd_addr = rec_rd.key[BKT_W-1:0];
            end

            S_UNCH_BKT:
            begin
                if (bkt_rd == victim_reg)
                begin
                    bkt_req.wr_en      = 1'b1;
                    bkt_req.wr_addr    = ubkt_reg;
                    bkt_req.wr_data    = vchain_reg;
                    bvld_next[ubkt_reg] = 1'b1;
                end
                else
                begin
                    cur_next   = bkt_rd;
                    steps_next = '0;
                    if (is_valid(bkt_rd))
                    begin
                        rec_req.rd_en   = 1'b1;
                        rec_req.rd_addr = bkt_rd;
                    end
                end
            end

            S_UNCH_WALK:
            begin
                if (rec_rd.chain == victim_reg)
                begin
                    rec_req.wr_en         = 1'b1;
                    rec_req.wr_addr       = cur_reg;
                    rec_req.wr_data.chain = vchain_reg;
                    rec_req.wr_mask       = MASK_CHAIN;
                end
                else if (!walk_end)
                begin
                    rec_req.rd_en   = 1'b1;
                    rec_req.rd_addr = rec_rd.chain;
                    cur_next        = rec_rd.chain;
                    steps_next      = steps_inc;
                end
            end

            S_NEW_RQ:
            begin
                bkt_req.rd_en   = 1'b1;
                bkt_req.rd_addr = ip_bkt;
            end

            S_NEW_BKT:
            begin
                // Fill the new entry and put it at the head of its bucket.
                rec_req.wr_en         = 1'b1;
                rec_req.wr_addr       = victim_reg;
                rec_req.wr_mask       = MASK_ALL;
                rec_req.wr_data.key   = item_reg.ip_addr;
                rec_req.wr_data.tag   = '0;
                rec_req.wr_data.refc  = 7'd1;
                rec_req.wr_data.chain = bkt_rd;
                rec_req.wr_data.prev  = NIL;
                rec_req.wr_data.nxt   = NIL;
                bkt_req.wr_en         = 1'b1;
                bkt_req.wr_addr       = ip_bkt;
                bkt_req.wr_data       = victim_reg;
                bvld_next[ip_bkt]     = 1'b1;
                res_next.result_entry = victim_reg;
                res_next.entry_addr   = item_reg.ip_addr;
                if (!busy_reg)
                begin
                    pend_next            = victim_reg;
                    busy_next            = 1'b1;
                    res_next.issue_query = 1'b1;
                    res_next.query_addr  = item_reg.ip_addr;
                end
                else
                begin
                    rec_req.wr_data.prev = qt_reg;
                    sl_en_next[2]        = is_valid(qt_reg);
                    sl_addr_next[2]      = qt_reg;
                    sl_val_next[2]       = victim_reg;
                    if (!is_valid(qt_reg))
                    begin
                        qh_next = victim_reg;
                    end
                    qt_next = victim_reg;
                end
            end

            S_REL_RD:
            begin
                if (!ref_zero)
                begin
                    rec_req.wr_en        = 1'b1;
                    rec_req.wr_addr      = cur_reg;
                    rec_req.wr_data.refc = rec_rd.refc - 7'd1;
                    rec_req.wr_mask      = MASK_REF;
                    if (rec_rd.refc == 7'd1)
                    begin
                        // Leave the resolver queue, then join the free list.
                        if (rel_inq)
                        begin
                            sl_en_next[0]   = is_valid(rec_rd.prev);
                            sl_addr_next[0] = rec_rd.prev;
                            sl_val_next[0]  = rec_rd.nxt;
                            sl_en_next[1]   = is_valid(rec_rd.nxt);
                            sl_addr_next[1] = rec_rd.nxt;
                            sl_val_next[1]  = rec_rd.prev;
                            if (!is_valid(rec_rd.prev))
                            begin
                                qh_next = rec_rd.nxt;
                            end
                            if (!is_valid(rec_rd.nxt))
                            begin
                                qt_next = rec_rd.prev;
                            end
                        end
                        rec_req.wr_mask      = MASK_RLINK;
                        rec_req.wr_data.prev = ft_reg;
                        rec_req.wr_data.nxt  = NIL;
                        sl_en_next[2]        = is_valid(ft_reg);
                        sl_addr_next[2]      = ft_reg;
                        sl_val_next[2]       = cur_reg;
                        if (!is_valid(ft_reg))
                        begin
                            fh_next = cur_reg;
                        end
                        ft_next = cur_reg;
                        fc_next = fc_reg + CNT_W'(1);
                    end
                end
            end

            S_REP_Q:
            begin
                if (is_valid(qh_reg))
                begin
                    cur_next        = qh_reg;
                    rec_req.rd_en   = 1'b1;
                    rec_req.rd_addr = qh_reg;
                end
                else
                begin
                    pend_next = NIL;
                    busy_next = 1'b0;
                end
            end

            S_REP_RD:
            begin
                // Dequeue the head entry and query it.
                sl_en_next[0]   = is_valid(rec_rd.prev);
                sl_addr_next[0] = rec_rd.prev;
                sl_val_next[0]  = rec_rd.nxt;
                sl_en_next[1]   = is_valid(rec_rd.nxt);
                sl_addr_next[1] = rec_rd.nxt;
                sl_val_next[1]  = rec_rd.prev;
                if (!is_valid(rec_rd.prev))
                begin
                    qh_next = rec_rd.nxt;
                end
                if (!is_valid(rec_rd.nxt))
                begin
                    qt_next = rec_rd.prev;
                end
                rec_req.wr_en         = 1'b1;
                rec_req.wr_addr       = cur_reg;
                rec_req.wr_data.prev  = NIL;
                rec_req.wr_data.nxt   = NIL;
                rec_req.wr_mask       = MASK_LINKS;
                pend_next             = cur_reg;
                busy_next             = 1'b1;
                res_next.issue_query  = 1'b1;
                res_next.query_addr   = rec_rd.key;
                res_next.result_entry = cur_reg;
                res_next.entry_tag    = rec_rd.tag;
                res_next.entry_addr   = rec_rd.key;
            end

            S_READ_RD:
            begin
                res_next.entry_tag  = rec_rd.tag;
                res_next.entry_addr = rec_rd.key;
            end

            S_LINK:
            begin
                // Slot one rewrites a previous pointer, the others a next pointer.
                rec_req.wr_mask = MASK_NEXT;
                case (sl_idx_reg)
                    2'd0:
                    begin
                        rec_req.wr_en   = sl_en_reg[0];
                        rec_req.wr_addr = sl_addr_reg[0];
                        rec_req.wr_data.nxt = sl_val_reg[0];
                    end
                    2'd1:
                    begin
                        rec_req.wr_en   = sl_en_reg[1];
                        rec_req.wr_addr = sl_addr_reg[1];
                        rec_req.wr_data.prev = sl_val_reg[1];
                        rec_req.wr_mask = MASK_PREV;
                    end
                    default:
                    begin
                        rec_req.wr_en   = sl_en_reg[2];
                        rec_req.wr_addr = sl_addr_reg[2];
                        rec_req.wr_data.nxt = sl_val_reg[2];
                    end
                endcase
                sl_idx_next = sl_idx_reg + 2'd1;
            end

            S_DONE:
            begin
            end

            default:
            begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fh_reg     <= NIL;
            ft_reg     <= NIL;
            qh_reg     <= NIL;
            qt_reg     <= NIL;
            pend_reg   <= NIL;
            used_reg   <= '0;
            fc_reg     <= '0;
            busy_reg   <= 1'b0;
            bvld_reg   <= '0;
            sl_en_reg  <= '0;
            sl_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fh_reg     <= fh_next;
            ft_reg     <= ft_next;
            qh_reg     <= qh_next;
            qt_reg     <= qt_next;
            pend_reg   <= pend_next;
            used_reg   <= used_next;
            fc_reg     <= fc_next;
            busy_reg   <= busy_next;
            bvld_reg   <= bvld_next;
            sl_en_reg  <= sl_en_next;
            sl_idx_reg <= sl_idx_next;
        end
    end

    // Working payload.
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        res_reg     <= res_next;
        cur_reg     <= cur_next;
        steps_reg   <= steps_next;
        victim_reg  <= victim_next;
        vchain_reg  <= vchain_next;
        ubkt_reg    <= ubkt_next;
        sl_addr_reg <= sl_addr_next;
        sl_val_reg  <= sl_val_next;
        if (rec_req.rd_en)
        begin
            rd_addr_reg <= rec_req.rd_addr;
        end
        if (bkt_req.rd_en)
        begin
            brd_addr_reg <= bkt_req.rd_addr;
        end
    end

endmodule

[hw/rtl/address_name_cache_core.sv]
// Throughput: one item at a time; the next item is taken once the result has moved
// to the output register. Reset: no clearing pass; the fill count and bucket valid
// bits make the store read as cleared as soon as reset is released.
// ----------------------------------------------------------------------------
// address_name_cache_core
// Reference counted address cache with a resolver request queue.
// ----------------------------------------------------------------------------
module address_name_cache_core
    import acn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  in_item_t   req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output out_item_t  rsp
);

    rec_port_t         rec_req;
    bkt_port_t         bkt_req;
    logic [REC_W-1:0]  rec_raw;
    logic [IDX_W-1:0]  bkt_raw;
    out_item_t         result;
    logic              done;
    logic              take;
    logic              rsp_valid_reg, rsp_valid_next;
    out_item_t         rsp_reg;

    acn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .done      (done),
        .take      (take),
        .result    (result),
        .rec_req   (rec_req),
        .rec_raw   (rec_t'(rec_raw)),
        .bkt_req   (bkt_req),
        .bkt_raw   (bkt_raw)
    );

    acn_ram #(.WIDTH(REC_W), .DEPTH(CAP)) u_rec_ram (
        .clk     (clk),
        .rd_en   (rec_req.rd_en),
        .rd_addr (rec_req.rd_addr),
        .rd_data (rec_raw),
        .wr_en   (rec_req.wr_en),
        .wr_addr (rec_req.wr_addr),
        .wr_data (rec_req.wr_data),
        .wr_mask (rec_req.wr_mask)
    );

    acn_ram #(.WIDTH(IDX_W), .DEPTH(BUCKETS)) u_bkt_ram (
        .clk     (clk),
        .rd_en   (bkt_req.rd_en),
        .rd_addr (bkt_req.rd_addr),
        .rd_data (bkt_raw),
        .wr_en   (bkt_req.wr_en),
        .wr_addr (bkt_req.wr_addr),
        .wr_data (bkt_req.wr_data),
        .wr_mask ({IDX_W{1'b1}})
    );

    // Output register: a finished item moves here when the slot is free or is being emptied.
    assign take = done && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[hw/rtl/acn_checker.sv]
// ----------------------------------------------------------------------------
// acn_checker
// Port level checks of the address name cache, bound to the top level.
// ----------------------------------------------------------------------------
module acn_checker
    import acn_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input in_item_t   req,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input out_item_t  rsp
);

    // A waiting result item holds still.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    // One item at a time: the input closes after an accept.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input open right after an accept");

    // No query address without a query.
    a_query_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.issue_query |-> rsp.query_addr == '0)
        else $error("query address without a query");

    // A hit names a real entry.
    a_hit_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.hit |-> rsp.result_entry < NIL)
        else $error("hit on an entry beyond capacity");

    // A full table reports nothing else.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status && !rsp.hit
            |-> rsp.result_entry == '0 && rsp.entry_addr == '0 && !rsp.issue_query)
        else $error("table full result carries an entry");

endmodule

bind address_name_cache_core acn_checker u_acn_checker (.*);
